>>> design/crcwb_pkg.sv
`timescale 1ns / 1ps

package crcwb_pkg;

    localparam int CRC_W = 32;
    localparam int BYTE_W = 8;
    localparam int BYTE_LANE_SHIFT = CRC_W - BYTE_W;
    localparam int CNT_W = $clog2(CRC_W);

    localparam logic [CRC_W-1:0] CRC_ALL_ONES = {CRC_W{1'b1}};
    localparam logic [CRC_W-1:0] CRC_DEFAULT_POLY = 32'h04C1_1DB7;

    // opcode of an input transaction
    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_RESET = 2'd2
    } opcode_t;

    // entry k holds the register after k+1 shift steps starting from the top bit alone
    typedef logic [CRC_W-1:0][CRC_W-1:0] crc_table_t;

    // one shift step, polynomial folded in when the top bit leaves
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] acc,
                                                  input logic [CRC_W-1:0] poly);
        crc_step = acc[CRC_W-1] ? ({acc[CRC_W-2:0], 1'b0} ^ poly)
                                : {acc[CRC_W-2:0], 1'b0};
    endfunction

    // full column table for a polynomial, used for the reset value only
    function automatic crc_table_t build_table(input logic [CRC_W-1:0] poly);
        crc_table_t       tbl;
        logic [CRC_W-1:0] h;
        h = poly;
        for (int k = 0; k < CRC_W; k++) begin
            tbl[k] = h;
            h = crc_step(h, poly);
        end
        build_table = tbl;
    endfunction

    localparam crc_table_t DEFAULT_TABLE = build_table(CRC_DEFAULT_POLY);

endpackage

>>> design/crcwb_table.sv
`timescale 1ns / 1ps

module crcwb_table import crcwb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CRC_W-1:0] cfg_wr_data,
    output crc_table_t       table_out,
    output logic             busy
);

    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] cur_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    crc_table_t       table_reg;

    // column rebuild, one shift step per cycle after a polynomial write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= CRC_DEFAULT_POLY;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            table_reg <= DEFAULT_TABLE;
        end else if (cfg_wr_en) begin
            poly_reg <= cfg_wr_data;
            cur_reg  <= cfg_wr_data;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            table_reg[cnt_reg] <= cur_reg;
            cur_reg            <= crc_step(cur_reg, poly_reg);
            cnt_reg            <= cnt_reg + 1'b1;
            busy_reg           <= (cnt_reg != CNT_W'(CRC_W - 1));
        end
    end

    assign table_out = table_reg;
    assign busy      = busy_reg;

endmodule

>>> design/crcwb_core.sv
`timescale 1ns / 1ps

module crcwb_core import crcwb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             enable,
    input  crc_table_t       table_in,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic             s_start_message,
    input  logic [CRC_W-1:0] s_data_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CRC_W-1:0] m_crc_value
);

    logic             in_valid_reg;
    logic [1:0]       op_reg;
    logic             start_reg;
    logic [CRC_W-1:0] data_reg;
    logic [CRC_W-1:0] crc_reg;
    logic             m_valid_reg;
    logic [CRC_W-1:0] m_crc_reg;

    logic             advance;
    logic [CRC_W-1:0] base;
    logic [CRC_W-1:0] word_in;
    logic [CRC_W-1:0] byte_in;
    logic [CRC_W-1:0] word_res;
    logic [CRC_W-1:0] byte_res;
    logic [CRC_W-1:0] crc_next;

    // handshake: input stage refills when enabled and it is empty or the result stage can move
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = enable && (!in_valid_reg || advance);

    // start flag reloads all ones ahead of the element
    assign base    = start_reg ? CRC_ALL_ONES : crc_reg;
    assign word_in = base ^ data_reg;
    assign byte_in = base ^ {data_reg[BYTE_W-1:0], {BYTE_LANE_SHIFT{1'b0}}};

    // word: xor of table columns picked by each bit
    always_comb begin
        word_res = '0;
        for (int j = 0; j < CRC_W; j++) begin
            if (word_in[j]) begin
                word_res = word_res ^ table_in[j];
            end
        end
    end

    // byte: low bits shift up, top byte folds through the first columns
    always_comb begin
        byte_res = {byte_in[BYTE_LANE_SHIFT-1:0], {BYTE_W{1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (byte_in[BYTE_LANE_SHIFT+i]) begin
                byte_res = byte_res ^ table_in[i];
            end
        end
    end

    // opcode select, unused code passes the base value on (the register, or all ones on a start flag)
    always_comb begin
        unique case (opcode_t'(op_reg))
            OP_WORD:  crc_next = word_res;
            OP_BYTE:  crc_next = byte_res;
            OP_RESET: crc_next = CRC_ALL_ONES;
            default:  crc_next = base;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
            op_reg       <= s_opcode;
            start_reg    <= s_start_message;
            data_reg     <= s_data_value;
        end
    end

    // running crc and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_ALL_ONES;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                crc_reg   <= crc_next;
                m_crc_reg <= crc_next;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = m_crc_reg;

endmodule

>>> design/crc32_word_byte_engine.sv
`timescale 1ns / 1ps
// a transaction is loaded into the input register when accepted, then into the result register
// when the result stage can move
// throughput: one word or byte per cycle, set by the single-pass column xor network, while no
// table rebuild and no m_ready stall holds the flow; a polynomial write rebuilds the 32-entry
// column table, one shift step a cycle, and s_ready is low while the rebuild runs
// reset: crc register to all ones, polynomial to 0x04C11DB7, table loaded with its columns

module crc32_word_byte_engine import crcwb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CRC_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic             s_start_message,
    input  logic [CRC_W-1:0] s_data_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CRC_W-1:0] m_crc_value
);

    crc_table_t crc_table;
    logic       table_busy;
    logic       core_enable;

    // no transaction enters while the table is being rebuilt
    assign core_enable = !table_busy;

    crcwb_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .table_out   (crc_table),
        .busy        (table_busy)
    );

    crcwb_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .enable          (core_enable),
        .table_in        (crc_table),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_start_message (s_start_message),
        .s_data_value    (s_data_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_crc_value     (m_crc_value)
    );

endmodule
